### rtl/gqg_pkg.sv
// Shared constants, types and saturation helper for the glyph quad generator.
package gqg_pkg;

    localparam int GLYPH_COUNT_DEF = 95;
    localparam logic [7:0] FIRST_CODE = 8'd32;

    localparam int XY_W   = 16;
    localparam int U_W    = 17;
    localparam int GW_W   = 8;
    localparam int CFG_W  = 8;
    localparam int ENTRY_W = U_W + U_W + GW_W;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_PEN  = 2'd1;
    localparam logic [1:0] CMD_DRAW = 2'd2;

    localparam logic [1:0] REG_SPACE  = 2'd0;
    localparam logic [1:0] REG_GAP    = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [2:0] VTX_LAST = 3'd5;

    localparam logic [7:0] SPACE_RST  = 8'd3;
    localparam logic [7:0] GAP_RST    = 8'd1;
    localparam logic [7:0] HEIGHT_RST = 8'd16;

    typedef struct packed {
        logic signed [XY_W-1:0] xl;
        logic signed [XY_W-1:0] xr;
        logic signed [XY_W-1:0] yt;
        logic signed [XY_W-1:0] yb;
        logic [U_W-1:0]         left;
        logic [U_W-1:0]         right;
    } quad_t;

    function automatic logic signed [XY_W-1:0] sat16(input logic signed [XY_W+1:0] v);
        logic signed [XY_W-1:0] r;
        if (v > 18'sd32767)
            r = 16'sh7FFF;
        else if (v < -18'sd32768)
            r = 16'sh8000;
        else
            r = v[XY_W-1:0];
        return r;
    endfunction

endpackage

### rtl/glyph_quad_generator.sv
// Glyph quad generator top level: command decode, glyph table, pen state and emitter.
//
// Usage: commands arrive on the input channel (in_valid/in_stall). A load writes one
// glyph table entry, a set-pen places the pen, a draw takes one character code.
// Each printable drawn character gives six vertex items on the output channel
// (out_valid/out_stall) in the order TL, BR, BL, TL, TR, BR, last set on the sixth.
// Spaces, loads, set-pen, out-of-range codes and command 3 give no items.
// The glyph entry is read from the table memory in the accept cycle; the decode stage
// then loads the quad into the emitter once it is free, and the emitter shows the first vertex.
// One command per cycle is taken for commands without output, unless a draw in the
// decode stage waits for the emitter; a drawn character holds the emitter for all six
// of its vertices. The next command is taken while vertices still go.
// Stall: out_stall holds the current vertex; once the emitter and the decode stage
// are both full, in_stall rises until the emitter frees.
// Reset: pen goes to (0,0), space advance 3, gap 1, height 16. The glyph table is
// not cleared; configuration writes on cfg_write take effect at the next edge.
module glyph_quad_generator #(
    parameter int GLYPH_COUNT = gqg_pkg::GLYPH_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [1:0]                      cfg_index,
    input  logic [gqg_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      command,
    input  logic [7:0]                      char_code,
    input  logic signed [gqg_pkg::XY_W-1:0] pen_x_in,
    input  logic signed [gqg_pkg::XY_W-1:0] pen_y_in,
    input  logic [gqg_pkg::U_W-1:0]         tex_left_in,
    input  logic [gqg_pkg::U_W-1:0]         tex_right_in,
    input  logic [gqg_pkg::GW_W-1:0]        width_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [gqg_pkg::XY_W-1:0] vert_x,
    output logic signed [gqg_pkg::XY_W-1:0] vert_y,
    output logic [gqg_pkg::U_W-1:0]         tex_u,
    output logic                            tex_v,
    output logic                            last
);
    import gqg_pkg::*;

    localparam int AW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

    logic [CFG_W-1:0] space_reg, gap_reg, height_reg;

    logic             s1_valid_reg, s1_valid_next;
    logic             s1_quad_reg, s1_space_reg, s1_pen_reg;
    logic signed [XY_W-1:0] s1_px_reg, s1_py_reg;
    logic signed [XY_W-1:0] pen_x_reg, pen_x_next;
    logic signed [XY_W-1:0] pen_y_reg, pen_y_next;

    logic             accept;
    logic             s1_go;
    logic             em_free;
    logic             em_load;
    logic [7:0]       idx;
    logic             in_range;
    logic [ENTRY_W-1:0] rdata;
    logic [U_W-1:0]   g_left, g_right;
    logic [GW_W-1:0]  g_width;
    logic signed [XY_W+1:0] px_ext, py_ext;
    quad_t            quad;

    assign idx      = char_code - FIRST_CODE;
    assign in_range = (char_code >= FIRST_CODE) && ({1'b0, idx} < 9'(GLYPH_COUNT));

    assign s1_go    = s1_valid_reg && (!s1_quad_reg || em_free);
    assign in_stall = s1_valid_reg && !s1_go;
    assign accept   = in_valid && !in_stall;
    assign em_load  = s1_go && s1_quad_reg;

    gqg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (GLYPH_COUNT),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (accept && (command == CMD_LOAD) && in_range),
        .waddr (idx[AW-1:0]),
        .wdata ({tex_left_in, tex_right_in, width_in}),
        .re    (accept && (command == CMD_DRAW)),
        .raddr (idx[AW-1:0]),
        .rdata (rdata)
    );

    assign {g_left, g_right, g_width} = rdata;

    assign px_ext = {{2{pen_x_reg[XY_W-1]}}, pen_x_reg};
    assign py_ext = {{2{pen_y_reg[XY_W-1]}}, pen_y_reg};

    always_comb
    begin
        quad.xl    = pen_x_reg;
        quad.yt    = pen_y_reg;
        quad.xr    = sat16(px_ext + $signed({10'd0, g_width}));
        quad.yb    = sat16(py_ext - $signed({10'd0, height_reg}));
        quad.left  = g_left;
        quad.right = g_right;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;

        pen_x_next = pen_x_reg;
        pen_y_next = pen_y_reg;
        if (s1_go)
        begin
            if (s1_pen_reg)
            begin
                pen_x_next = s1_px_reg;
                pen_y_next = s1_py_reg;
            end
            else if (s1_space_reg)
            begin
                pen_x_next = sat16(px_ext + $signed({10'd0, space_reg}));
            end
            else if (s1_quad_reg)
            begin
                pen_x_next = sat16(px_ext + $signed({10'd0, g_width})
                                   + $signed({10'd0, gap_reg}));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_quad_reg  <= 1'b0;
            s1_space_reg <= 1'b0;
            s1_pen_reg   <= 1'b0;
            pen_x_reg    <= '0;
            pen_y_reg    <= '0;
            space_reg    <= SPACE_RST;
            gap_reg      <= GAP_RST;
            height_reg   <= HEIGHT_RST;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            pen_x_reg    <= pen_x_next;
            pen_y_reg    <= pen_y_next;
            if (accept)
            begin
                s1_pen_reg   <= (command == CMD_PEN);
                s1_space_reg <= (command == CMD_DRAW) && in_range && (idx == 8'd0);
                s1_quad_reg  <= (command == CMD_DRAW) && in_range && (idx != 8'd0);
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SPACE:  space_reg  <= cfg_data;
                    REG_GAP:    gap_reg    <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg <= pen_x_in;
            s1_py_reg <= pen_y_in;
        end
    end

    gqg_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (em_load),
        .quad      (quad),
        .free      (em_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .vert_x    (vert_x),
        .vert_y    (vert_y),
        .tex_u     (tex_u),
        .tex_v     (tex_v),
        .last      (last)
    );

endmodule

### rtl/gqg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module gqg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/gqg_emit.sv
// Vertex emitter: holds one quad and sends its six vertices on the output channel.
module gqg_emit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  gqg_pkg::quad_t               quad,
    output logic                         free,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [gqg_pkg::XY_W-1:0] vert_x,
    output logic signed [gqg_pkg::XY_W-1:0] vert_y,
    output logic [gqg_pkg::U_W-1:0]      tex_u,
    output logic                         tex_v,
    output logic                         last
);
    import gqg_pkg::*;

    logic       busy_reg, busy_next;
    logic [2:0] cnt_reg, cnt_next;
    quad_t      quad_reg;
    logic       use_right;
    logic       bottom;
    logic       at_last;

    assign at_last = (cnt_reg == VTX_LAST);
    assign free    = !busy_reg || (at_last && !out_stall);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
        end
        else if (busy_reg && !out_stall)
        begin
            if (at_last)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quad_reg <= quad;
        end
    end

    // Order TL, BR, BL, TL, TR, BR
    always_comb
    begin
        case (cnt_reg)
            3'd0:    begin use_right = 1'b0; bottom = 1'b0; end
            3'd1:    begin use_right = 1'b1; bottom = 1'b1; end
            3'd2:    begin use_right = 1'b0; bottom = 1'b1; end
            3'd3:    begin use_right = 1'b0; bottom = 1'b0; end
            3'd4:    begin use_right = 1'b1; bottom = 1'b0; end
            default: begin use_right = 1'b1; bottom = 1'b1; end
        endcase
    end

    assign out_valid = busy_reg;
    assign vert_x    = use_right ? quad_reg.xr : quad_reg.xl;
    assign vert_y    = bottom ? quad_reg.yb : quad_reg.yt;
    assign tex_u     = use_right ? quad_reg.right : quad_reg.left;
    assign tex_v     = bottom;
    assign last      = at_last;

endmodule

### bench/glyph_quad_generator_test.sv
// Self-checking bench for the glyph quad generator: directed and random command streams.
module glyph_quad_generator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gqg_pkg::*;

    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int GLYPHS = GLYPH_COUNT_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 26;

    typedef struct {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [U_W-1:0]         u;
        logic                   v;
        logic                   last;
    } vertex_t;

    // Tracks glyph table, pen and registers; holds the vertices still due from the block.
    class glyph_vertex_board;
        logic [U_W-1:0]  tex_l [GLYPHS];
        logic [U_W-1:0]  tex_r [GLYPHS];
        logic [GW_W-1:0] glyph_w [GLYPHS];
        bit              loaded [GLYPHS];
        int              pen_x;
        int              pen_y;
        int              space_adv;
        int              gap;
        int              row_height;
        vertex_t         due [$];
        int              errors;
        int              checked;
        int              quads;
        int              spaces;

        function new();
            pen_x = 0;
            pen_y = 0;
            space_adv = int'(SPACE_RST);
            gap = int'(GAP_RST);
            row_height = int'(HEIGHT_RST);
            errors = 0;
            checked = 0;
            quads = 0;
            spaces = 0;
            foreach (loaded[i])
                loaded[i] = 1'b0;
        endfunction

        function int clamp16(int v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        endfunction

        function bit has_glyph(logic [7:0] code);
            int idx;
            idx = int'(code) - int'(FIRST_CODE);
            return idx >= 0 && idx < GLYPHS && loaded[idx];
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_SPACE:  space_adv = int'(val);
                REG_GAP:    gap = int'(val);
                REG_HEIGHT: row_height = int'(val);
                default:    ;
            endcase
        endfunction

        function void push_vertex(int x, int y, logic [U_W-1:0] u, logic v, logic lst);
            vertex_t vx;
            vx.x = XY_W'(x);
            vx.y = XY_W'(y);
            vx.u = u;
            vx.v = v;
            vx.last = lst;
            due.push_back(vx);
        endfunction

        function void take_command(logic [1:0] cmd, logic [7:0] code,
                                   logic signed [XY_W-1:0] px, logic signed [XY_W-1:0] py,
                                   logic [U_W-1:0] tl, logic [U_W-1:0] tr,
                                   logic [GW_W-1:0] w);
            int idx;
            int xl, xr, yt, yb;
            idx = int'(code) - int'(FIRST_CODE);
            case (cmd)
                CMD_LOAD:
                    if (idx >= 0 && idx < GLYPHS)
                    begin
                        tex_l[idx] = tl;
                        tex_r[idx] = tr;
                        glyph_w[idx] = w;
                        loaded[idx] = 1'b1;
                    end
                CMD_PEN:
                begin
                    pen_x = int'(px);
                    pen_y = int'(py);
                end
                CMD_DRAW:
                    if (idx == 0)
                    begin
                        pen_x = clamp16(pen_x + space_adv);
                        spaces++;
                    end
                    else if (idx > 0 && idx < GLYPHS)
                    begin
                        xl = pen_x;
                        xr = clamp16(pen_x + int'(glyph_w[idx]));
                        yt = pen_y;
                        yb = clamp16(pen_y - row_height);
                        push_vertex(xl, yt, tex_l[idx], 1'b0, 1'b0);
                        push_vertex(xr, yb, tex_r[idx], 1'b1, 1'b0);
                        push_vertex(xl, yb, tex_l[idx], 1'b1, 1'b0);
                        push_vertex(xl, yt, tex_l[idx], 1'b0, 1'b0);
                        push_vertex(xr, yt, tex_r[idx], 1'b0, 1'b0);
                        push_vertex(xr, yb, tex_r[idx], 1'b1, 1'b1);
                        pen_x = clamp16(pen_x + int'(glyph_w[idx]) + gap);
                        quads++;
                    end
                default: ;
            endcase
        endfunction

        function void field_mismatch(string name, int want, int got);
            errors++;
            if (errors <= 30)
                $display("%0t: %s mismatch on vertex %0d: expected %0d, got %0d",
                         $realtime, name, checked, want, got);
        endfunction

        function void match_vertex(logic signed [XY_W-1:0] x, logic signed [XY_W-1:0] y,
                                   logic [U_W-1:0] u, logic v, logic lst);
            vertex_t want;
            if (due.size() == 0)
            begin
                errors++;
                if (errors <= 30)
                    $display("%0t: unexpected vertex: expected none, got x=%0d y=%0d u=%0d",
                             $realtime, x, y, u);
                return;
            end
            want = due.pop_front();
            checked++;
            if (x !== want.x)
                field_mismatch("vert_x", int'(want.x), int'(x));
            if (y !== want.y)
                field_mismatch("vert_y", int'(want.y), int'(y));
            if (u !== want.u)
                field_mismatch("tex_u", int'(want.u), int'(u));
            if (v !== want.v)
                field_mismatch("tex_v", int'(want.v), int'(v));
            if (lst !== want.last)
                field_mismatch("last", int'(want.last), int'(lst));
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [1:0]             cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             command = '0;
    logic [7:0]             char_code = '0;
    logic signed [XY_W-1:0] pen_x_in = '0;
    logic signed [XY_W-1:0] pen_y_in = '0;
    logic [U_W-1:0]         tex_left_in = '0;
    logic [U_W-1:0]         tex_right_in = '0;
    logic [GW_W-1:0]        width_in = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic signed [XY_W-1:0] vert_x;
    logic signed [XY_W-1:0] vert_y;
    logic [U_W-1:0]         tex_u;
    logic                   tex_v;
    logic                   last;

    glyph_vertex_board board = new();

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int items_sent = 0;
    int input_stall_cycles = 0;

    glyph_quad_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .char_code    (char_code),
        .pen_x_in     (pen_x_in),
        .pen_y_in     (pen_y_in),
        .tex_left_in  (tex_left_in),
        .tex_right_in (tex_right_in),
        .width_in     (width_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .vert_x       (vert_x),
        .vert_y       (vert_y),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // Vertex receiver: check accepted items, then decide the stall for the next edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.match_vertex(vert_x, vert_y, tex_u, tex_v, last);
        if (hold_requests != holds_served)
        begin
            hold_left = HOLD_CYCLES;
            holds_served++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_item(logic [1:0] cmd, logic [7:0] code,
                             logic signed [XY_W-1:0] px, logic signed [XY_W-1:0] py,
                             logic [U_W-1:0] tl, logic [U_W-1:0] tr, logic [GW_W-1:0] w);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        char_code <= code;
        pen_x_in <= px;
        pen_y_in <= py;
        tex_left_in <= tl;
        tex_right_in <= tr;
        width_in <= w;
        @(posedge clk);
        while (in_stall)
        begin
            input_stall_cycles++;
            @(posedge clk);
        end
        board.take_command(cmd, code, px, py, tl, tr, w);
        items_sent++;
    endtask

    task automatic draw_char(logic [7:0] code);
        send_item(CMD_DRAW, code, XY_W'($urandom), XY_W'($urandom), U_W'($urandom),
                  U_W'($urandom), GW_W'($urandom));
    endtask

    task automatic load_glyph(logic [7:0] code, logic [U_W-1:0] tl, logic [U_W-1:0] tr,
                              logic [GW_W-1:0] w);
        send_item(CMD_LOAD, code, XY_W'($urandom), XY_W'($urandom), tl, tr, w);
    endtask

    task automatic place_pen(logic signed [XY_W-1:0] px, logic signed [XY_W-1:0] py);
        send_item(CMD_PEN, 8'($urandom), px, py, U_W'($urandom), U_W'($urandom),
                  GW_W'($urandom));
    endtask

    // Drop valid and wait until every vertex is out and the block has gone quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(logic [CFG_W-1:0] space_v, logic [CFG_W-1:0] gap_v,
                              logic [CFG_W-1:0] height_v);
        logic [CFG_W-1:0] vals [3];
        logic [1:0] idx [3];
        vals = '{space_v, gap_v, height_v};
        idx = '{REG_SPACE, REG_GAP, REG_HEIGHT};
        for (int i = 0; i < 3; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(posedge clk);
            board.set_reg(idx[i], vals[i]);
        end
        cfg_write <= 1'b0;
    endtask

    function automatic logic [U_W-1:0] pick_u();
        case ($urandom_range(3))
            0:       return '0;
            1:       return U_W'(65536);
            default: return U_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [XY_W-1:0] pick_xy();
        case ($urandom_range(5))
            0:       return 16'sh7F00 + XY_W'($urandom_range(255));
            1:       return 16'sh8000 + XY_W'($urandom_range(255));
            default: return XY_W'($urandom);
        endcase
    endfunction

    // One random command; mostly well-formed, some out-of-range codes and spare commands.
    task automatic random_command(output bit counted);
        logic [7:0] code;
        int pick;
        code = 8'($urandom);
        pick = $urandom_range(99);
        counted = 1'b1;
        if (pick < 12)
        begin
            if ($urandom_range(4) != 0)
                code = 8'($urandom_range(126, 33));
            load_glyph(code, pick_u(), pick_u(), GW_W'($urandom));
            counted = board.has_glyph(code);
        end
        else if (pick < 20)
            place_pen(pick_xy(), pick_xy());
        else if (pick < 26)
        begin
            counted = 1'b0;
            if ($urandom_range(1))
                send_item(CMD_SPARE, code, XY_W'($urandom), XY_W'($urandom),
                          U_W'($urandom), U_W'($urandom), GW_W'($urandom));
            else
            begin
                code = $urandom_range(1) ? 8'($urandom_range(31))
                                         : 8'($urandom_range(255, 127));
                draw_char(code);
            end
        end
        else if (pick < 34)
            draw_char(FIRST_CODE);
        else
        begin
            code = 8'($urandom_range(126, 33));
            if (board.has_glyph(code))
                draw_char(code);
            else
                load_glyph(code, pick_u(), pick_u(), GW_W'($urandom));
        end
    endtask

    initial
    begin
        int space_tbl [PHASES];
        int gap_tbl [PHASES];
        int height_tbl [PHASES];
        int send_tbl [PHASES];
        int stall_tbl [PHASES];
        int done;
        bit counted;
        int leftover;

        space_tbl  = '{0, 255, -1, -1, 3, -1, -1, 255};
        gap_tbl    = '{0, 255, -1, -1, 1, -1, -1, 0};
        height_tbl = '{0, 255, -1, -1, 16, -1, -1, 255};
        send_tbl   = '{0, 78, 0, 20, 0, 78, 0, 20};
        stall_tbl  = '{0, 0, 78, 20, 0, 0, 78, 20};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset registers, ignored codes, extreme glyphs and pen saturation.
        draw_char(FIRST_CODE);
        draw_char(8'd0);
        draw_char(8'd31);
        draw_char(8'd127);
        draw_char(8'd255);
        send_item(CMD_SPARE, 8'd65, '1, '1, '1, '1, '1);
        load_glyph(8'd31, '1, '1, '1);
        load_glyph(8'd127, '1, '1, '1);
        load_glyph(8'd255, '1, '1, '1);
        load_glyph(FIRST_CODE, 17'd100, 17'd200, 8'd9);
        load_glyph(8'd65, '0, U_W'(65536), 8'd8);
        load_glyph(8'd126, '1, '0, 8'd255);
        load_glyph(8'd33, 17'd12345, 17'd54321, 8'd0);
        draw_char(8'd65);
        draw_char(8'd126);
        draw_char(8'd33);
        place_pen(16'sh7FFF, 16'sh8000);
        draw_char(8'd126);
        draw_char(FIRST_CODE);
        place_pen(16'sh8000, 16'sh7FFF);
        draw_char(8'd65);
        draw_char(FIRST_CODE);
        draw_char(8'd65);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            write_regs(space_tbl[p] < 0 ? CFG_W'($urandom) : CFG_W'(space_tbl[p]),
                       gap_tbl[p] < 0 ? CFG_W'($urandom) : CFG_W'(gap_tbl[p]),
                       height_tbl[p] < 0 ? CFG_W'($urandom) : CFG_W'(height_tbl[p]));
            send_idle_pct = send_tbl[p];
            stall_pct <= stall_tbl[p];
            // Hold the output off for a long stretch so the block backs up its input.
            if (p == 4)
                hold_requests <= hold_requests + 1;
            done = 0;
            while (done < ITEMS_PER_PHASE)
            begin
                random_command(counted);
                if (counted)
                    done++;
            end
        end

        settle();
        leftover = board.pending();
        if (leftover != 0)
            $display("%0t: %0d expected vertices never arrived", $realtime, leftover);
        $display("Run: %0d commands, %0d quads and %0d spaces drawn, %0d vertices checked,",
                 items_sent, board.quads, board.spaces, board.checked);
        $display("     %0d input stall cycles over %0d register settings",
                 input_stall_cycles, PHASES + 1);
        if (board.errors == 0 && leftover == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### glyph_quad_generator.f
rtl/gqg_pkg.sv
rtl/gqg_ram.sv
rtl/gqg_emit.sv
rtl/glyph_quad_generator.sv
bench/glyph_quad_generator_test.sv
